// ===== design/mcr_pkg.sv =====
// Shared types, constants and helpers for the midpoint circle rasterizer.
// No dependencies; every design file imports this package.
`default_nettype none

package mcr_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 88;
  localparam int unsigned RESULT_LIMIT   = 64;
  localparam int unsigned CNT_W          = $clog2(RESULT_LIMIT);
  localparam int unsigned GROUND_OFFSET  = 50;
  localparam int unsigned QDEPTH         = 2;
  localparam int unsigned QPTR_W         = $clog2(QDEPTH);
  localparam int unsigned QCNT_W         = $clog2(QDEPTH + 1);

  // screen centre coordinate width
  localparam int unsigned CW = 26;

  localparam logic [1:0] CFG_SCREEN_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_PIXELS_PER_UNIT = 2'd2;

  localparam logic [11:0] SCREEN_WIDTH_RST    = 12'd800;
  localparam logic [11:0] SCREEN_HEIGHT_RST   = 12'd600;
  localparam logic [15:0] PIXELS_PER_UNIT_RST = 16'd12800;

  typedef struct packed {
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic        [30:0] circle_radius;
    logic        [7:0]  red_in;
    logic        [7:0]  green_in;
    logic        [7:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] cx_plus_x;
    logic signed [15:0] cx_minus_x;
    logic signed [15:0] cx_plus_y;
    logic signed [15:0] cx_minus_y;
    logic signed [15:0] cy_plus_x;
    logic signed [15:0] cy_minus_x;
    logic signed [15:0] cy_plus_y;
    logic signed [15:0] cy_minus_y;
    logic        [7:0]  red_out;
    logic        [7:0]  green_out;
    logic        [7:0]  blue_out;
    logic               final_step;
  } out_item_t;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [15:0] pixels_per_unit;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic        [7:0]    red;
    logic        [7:0]    green;
    logic        [7:0]    blue;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL_X,
    F_MUL_Y,
    F_MUL_R,
    F_ISSUE
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] lo;
    logic signed [15:0]   res;
    hi = CW'(32767);
    lo = -hi - CW'(1);
    if (v > hi) begin
      res = 16'sh7fff;
    end else if (v < lo) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/midpoint_circle_rasterizer.sv =====
// Midpoint circle rasterizer top level: configuration registers, front end,
// command queue and back end. Depends on mcr_pkg, mcr_front, mcr_queue, mcr_back.
// Usage:
//   in_*  : one circle command per transaction (valid/ready, in_item_t).
//   out_* : one point set per midpoint step (valid/ready, out_item_t);
//           final_step marks the last transaction of a circle.
//   cfg_* : register writes (index, data); cfg_ready is always high. Write only
//           while the block is idle.
// Operation:
//   The front end accepts a command, makes three passes through its shared
//   32x16 multiplier and issues it once the queue has room; then in_ready rises
//   again. A two-entry queue lets it run ahead of the back end.
//   The back end loads a command and then gives one result per cycle, while
//   out_ready does not stall it, from its midpoint step unit, up to 64 results
//   per circle.
//   A circle whose screen radius is zero gives no transaction on out_*.
// Reset: synchronous, active low. Registers return to 800 / 600 / 12800, the
//   queue empties and out_valid drops.
// Stall: out_valid and out_data hold while out_ready is low; the back end
//   pauses, and the front end keeps accepting until the queue fills.
`default_nettype none

module midpoint_circle_rasterizer import mcr_pkg::*; #(
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned RW = $clog2(MAX_RADIUS + 1);

  cfg_t          cfg_r;
  q_status_t     q_status;
  logic          push, pop;
  cmd_t          push_cmd, head_cmd;
  logic [RW-1:0] push_rad, head_rad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width    <= SCREEN_WIDTH_RST;
      cfg_r.screen_height   <= SCREEN_HEIGHT_RST;
      cfg_r.pixels_per_unit <= PIXELS_PER_UNIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:    cfg_r.screen_width    <= cfg_data[11:0];
        CFG_SCREEN_HEIGHT:   cfg_r.screen_height   <= cfg_data[11:0];
        CFG_PIXELS_PER_UNIT: cfg_r.pixels_per_unit <= cfg_data;
        default: ;
      endcase
    end
  end

  mcr_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd),
    .push_rad (push_rad)
  );

  mcr_queue #(.MAX_RADIUS(MAX_RADIUS)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .push_rad (push_rad),
    .pop      (pop),
    .status   (q_status),
    .head_cmd (head_cmd),
    .head_rad (head_rad)
  );

  mcr_back #(.MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .head_cmd  (head_cmd),
    .head_rad  (head_rad),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("command queue underflow");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_pop_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !pop)
    else $error("back end popped twice in a row");
`endif

endmodule

`default_nettype wire

// ===== design/mcr_front.sv =====
// Front end: accepts circle commands and maps them to screen space with one
// shared 32x16 multiplier. Depends on mcr_pkg; feeds mcr_queue.
`default_nettype none

module mcr_front import mcr_pkg::*; #(
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire in_item_t                            in_data,
  input  wire cfg_t                                cfg,
  input  wire q_status_t                           q_status,
  output logic                                     push,
  output cmd_t                                     push_cmd,
  output logic [$clog2(MAX_RADIUS + 1)-1:0]        push_rad
);

  localparam int unsigned RW = $clog2(MAX_RADIUS + 1);

  front_state_t state_r, state_nxt;
  in_item_t     item_r;
  logic [47:0]  prod_r;
  logic         neg_r;
  logic signed [CW-1:0] cx_r;
  logic signed [CW-1:0] cy_r;

  logic signed [31:0]   op_v;
  logic        [31:0]   op_mag;
  logic        [47:0]   prod_nxt;
  logic        [23:0]   p_hi;
  logic signed [CW-1:0] p_mag;
  logic signed [CW-1:0] p_s;
  logic signed [CW-1:0] half_w;
  logic signed [CW-1:0] base_y;
  logic                 rad_zero;

  always_comb begin
    unique case (state_r)
      F_MUL_X: op_v = item_r.centre_x;
      F_MUL_Y: op_v = item_r.centre_y;
      default: op_v = $signed({1'b0, item_r.circle_radius});
    endcase
    op_mag   = op_v[31] ? (~op_v + 32'd1) : op_v;
    prod_nxt = 48'(op_mag) * 48'(cfg.pixels_per_unit);
    p_hi     = prod_r[47:24];
    p_mag    = $signed({{(CW - 24){1'b0}}, p_hi});
    p_s      = neg_r ? -p_mag : p_mag;
    half_w   = $signed({{(CW - 11){1'b0}}, cfg.screen_width[11:1]});
    base_y   = $signed({{(CW - 12){1'b0}}, cfg.screen_height}) - CW'(GROUND_OFFSET);
    rad_zero = (p_hi == 24'd0);
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = F_MUL_X;
      end
      F_MUL_X: state_nxt = F_MUL_Y;
      F_MUL_Y: state_nxt = F_MUL_R;
      F_MUL_R: state_nxt = F_ISSUE;
      F_ISSUE: begin
        if (rad_zero) begin
          state_nxt = F_IDLE;
        end else if (!q_status.full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) item_r <= in_data;
    if (state_r == F_MUL_X || state_r == F_MUL_Y || state_r == F_MUL_R) begin
      prod_r <= prod_nxt;
      neg_r  <= op_v[31];
    end
    if (state_r == F_MUL_Y) cx_r <= half_w + p_s;
    if (state_r == F_MUL_R) cy_r <= base_y - p_s;
  end

  always_comb begin
    push_cmd.cx    = cx_r;
    push_cmd.cy    = cy_r;
    push_cmd.red   = item_r.red_in;
    push_cmd.green = item_r.green_in;
    push_cmd.blue  = item_r.blue_in;
    if (p_hi > 24'(MAX_RADIUS)) begin
      push_rad = RW'(MAX_RADIUS);
    end else begin
      push_rad = p_hi[RW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/mcr_queue.sv =====
// Short command queue between front and back end.
// Depends on mcr_pkg.
`default_nettype none

module mcr_queue import mcr_pkg::*; #(
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                push,
  input  wire cmd_t                                push_cmd,
  input  wire logic [$clog2(MAX_RADIUS + 1)-1:0]   push_rad,
  input  wire logic                                pop,
  output q_status_t                                status,
  output cmd_t                                     head_cmd,
  output logic [$clog2(MAX_RADIUS + 1)-1:0]        head_rad
);

  localparam int unsigned RW = $clog2(MAX_RADIUS + 1);

  cmd_t              cmd_mem [QDEPTH];
  logic [RW-1:0]     rad_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign status.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign status.empty = (cnt_r == '0);
  assign head_cmd     = cmd_mem[rd_ptr_r];
  assign head_rad     = rad_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr_r] <= push_cmd;
      rad_mem[wr_ptr_r] <= push_rad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/mcr_back.sv =====
// Back end: runs the midpoint circle loop, one result per step, into the
// output register. Depends on mcr_pkg; drains mcr_queue.
`default_nettype none

module mcr_back import mcr_pkg::*; #(
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire q_status_t                           q_status,
  input  wire cmd_t                                head_cmd,
  input  wire logic [$clog2(MAX_RADIUS + 1)-1:0]   head_rad,
  output logic                                     pop,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output out_item_t                                out_data
);

  localparam int unsigned RW   = $clog2(MAX_RADIUS + 1);
  localparam int unsigned XW   = RW + 1;
  localparam int unsigned ERRW = RW + 3;

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r;
  logic signed [XW-1:0]   x_r, y_r;
  logic signed [ERRW-1:0] tx_r, ty_r, err_r, diam_r;
  logic        [CNT_W-1:0] cnt_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic signed [XW-1:0]   x1, y1;
  logic signed [ERRW-1:0] tx1, ty1, err1, err2;
  logic signed [CW-1:0]   xe, ye;
  logic                   emit, last;
  out_item_t              item;

  always_comb begin
    if (err_r <= 0) begin
      y1   = y_r + XW'(1);
      err1 = err_r + ty_r;
      ty1  = ty_r + ERRW'(2);
    end else begin
      y1   = y_r;
      err1 = err_r;
      ty1  = ty_r;
    end
    if (err1 > 0) begin
      x1   = x_r - XW'(1);
      tx1  = tx_r + ERRW'(2);
      err2 = err1 + tx1 - diam_r;
    end else begin
      x1   = x_r;
      tx1  = tx_r;
      err2 = err1;
    end
    last = (x1 < y1) || (cnt_r == CNT_W'(RESULT_LIMIT - 1));
    xe   = $signed({{(CW - XW){x_r[XW-1]}}, x_r});
    ye   = $signed({{(CW - XW){y_r[XW-1]}}, y_r});
    item.cx_plus_x  = sat16(cmd_r.cx + xe);
    item.cx_minus_x = sat16(cmd_r.cx - xe);
    item.cx_plus_y  = sat16(cmd_r.cx + ye);
    item.cx_minus_y = sat16(cmd_r.cx - ye);
    item.cy_plus_x  = sat16(cmd_r.cy + xe);
    item.cy_minus_x = sat16(cmd_r.cy - xe);
    item.cy_plus_y  = sat16(cmd_r.cy + ye);
    item.cy_minus_y = sat16(cmd_r.cy - ye);
    item.red_out    = cmd_r.red;
    item.green_out  = cmd_r.green;
    item.blue_out   = cmd_r.blue;
    item.final_step = last;
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          pop       = 1'b1;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        emit = !out_valid_r || out_ready;
        if (emit && last) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r  <= head_cmd;
      x_r    <= $signed({1'b0, head_rad}) - XW'(1);
      y_r    <= '0;
      tx_r   <= ERRW'(1);
      ty_r   <= ERRW'(1);
      diam_r <= $signed({2'b00, head_rad, 1'b0});
      err_r  <= ERRW'(1) - $signed({2'b00, head_rad, 1'b0});
      cnt_r  <= '0;
    end else if (emit) begin
      x_r   <= x1;
      y_r   <= y1;
      tx_r  <= tx1;
      ty_r  <= ty1;
      err_r <= err2;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (emit) out_data_r <= item;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
